// ===== rtl/dhfm_pkg.sv =====
// Package for the disparity hole fill block: status codes, frame limits and shared types.
// No dependencies.
package dhfm_pkg;

	typedef enum logic [2:0] {
		ST_KEPT     = 3'd0,
		ST_MEDIAN   = 3'd1,
		ST_MEAN     = 3'd2,
		ST_UNFILLED = 3'd3,
		ST_OUTSIDE  = 3'd4
	} fill_status_t;

	// frame store size; address is {row, col}
	localparam int MAX_COLS = 256;
	localparam int MAX_ROWS = 256;

	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	localparam logic [0:0] REG_FRAME_WIDTH  = 1'd0;
	localparam logic [0:0] REG_FRAME_HEIGHT = 1'd1;

	// start/done handshake between the sequencer and the divider
	typedef struct packed {
		logic        start;
		logic [14:0] dividend;
		logic [6:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic       done;
		logic [7:0] quotient;
	} div_rsp_t;

endpackage

// ===== rtl/dhfm_div.sv =====
// Restoring divider, one quotient bit per cycle, used for the window means.
// Depends on dhfm_pkg.
module dhfm_div
	import dhfm_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [14:0] num_q;
	logic [6:0]  den_q;
	logic [6:0]  rem_q;
	logic [7:0]  quo_q;
	logic [3:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [7:0]  trial;
	logic [8:0]  diff;

	assign trial = {rem_q, num_q[14]};
	assign diff  = {1'b0, trial} - {2'b00, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 4'd15;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 4'd1;
				if (cnt_q == 4'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// quotient fits 8 bits (mean of bytes), remainder stays below the divisor
	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.dividend;
			den_q <= req.divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[13:0], 1'b0};
			if (!diff[8]) begin
				rem_q <= diff[6:0];
				quo_q <= {quo_q[6:0], 1'b1};
			end else begin
				rem_q <= trial[6:0];
				quo_q <= {quo_q[6:0], 1'b0};
			end
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

// ===== rtl/disparity_hole_fill_median_top.sv =====
// Top level of the disparity hole fill block: frame store, window sequencer
// and result register. Depends on dhfm_pkg and dhfm_div.
//
// Load words write one byte into the frame store; the block stays ready, so
// loads go back to back at one per cycle. A query word reads the center pixel;
// an out-of-frame query skips the read, and a nonzero center pixel is kept as
// the result. A hole walks its 3x3 window one pixel per cycle through the
// single store read port (8 reads), then insertion-sorts up to eight values
// with one shared compare and takes the middle value or halves the middle pair.
// Failing two valid 3x3 neighbors it scans 5x5, 7x7 ... up to MAX_BOX x
// MAX_BOX one store read per cycle (24, 48, 80 reads) and divides the sum by
// the count in a 15-step serial divider; with no such window it is unfilled.
// The longest query is a hole that needs the widest window. The store has no
// reset; pixels must be loaded before they are queried. Frame limits MAX_COLS
// and MAX_ROWS are fixed in dhfm_pkg. A finished result moves into an output
// register, so the next word is taken while the result waits for out_ready;
// a later result holds in the sequencer until that register frees.
module disparity_hole_fill_median_top
	import dhfm_pkg::*;
#(
	parameter int MAX_BOX  = 9
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [0:0] cfg_index,
	input  logic [8:0] cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       mode,
	input  logic [7:0] pixel_row,
	input  logic [7:0] pixel_col,
	input  logic [7:0] pixel_value,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] result_row,
	output logic [7:0] result_col,
	output logic [7:0] filled_value,
	output logic [2:0] fill_status
);

	localparam int CW = $clog2(MAX_COLS);
	localparam int RW = $clog2(MAX_ROWS);
	localparam int AW = CW + RW;
	// widest odd window not above MAX_BOX
	localparam int MAX_RAD = (MAX_BOX - 1) / 2;
	// signed coordinate width large enough for row +- MAX_RAD
	localparam int SW = 11;

	typedef enum logic [3:0] {
		S_IDLE, S_CENTER_RD, S_CENTER, S_SCAN_RD, S_SCAN,
		S_SORT, S_MID, S_DIV_WAIT, S_NEXT_BOX, S_OUT
	} state_t;

	state_t state_q;

	logic [8:0] width_q, height_q;
	logic [8:0] eff_w, eff_h;

	logic [7:0] mem [MAX_ROWS * MAX_COLS];
	logic [7:0] rd_data_q;
	logic [AW-1:0] rd_addr;

	logic [7:0] row_q, col_q;
	logic [7:0] value_q;
	fill_status_t status_q;
	logic [3:0] rad_q;
	logic signed [SW-1:0] dr_q, dc_q;
	logic signed [SW-1:0] cur_r, cur_c;
	logic cur_in;
	logic pend_q;
	logic [6:0] cnt_q;
	logic [14:0] sum_q;
	logic [7:0] vals_q [8];
	logic [2:0] si_q, sj_q;
	logic [2:0] mid_lo, mid_hi;
	logic [8:0] mid_sum;

	// output register
	logic out_valid_q;
	logic res_load;
	logic [7:0] res_row_q, res_col_q, res_value_q;
	fill_status_t res_status_q;

	div_req_t div_req;
	div_rsp_t div_rsp;

	assign eff_w = (width_q > 9'(MAX_COLS)) ? 9'(MAX_COLS) : width_q;
	assign eff_h = (height_q > 9'(MAX_ROWS)) ? 9'(MAX_ROWS) : height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 9'd256;
			height_q <= 9'd256;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH:  width_q  <= cfg_data;
				REG_FRAME_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cur_r  = $signed({3'b000, row_q}) + dr_q;
	assign cur_c  = $signed({3'b000, col_q}) + dc_q;
	assign cur_in = (cur_r >= 0) && (cur_c >= 0) &&
		(cur_r < $signed({2'b00, eff_h})) && (cur_c < $signed({2'b00, eff_w})) &&
		!((dr_q == 0) && (dc_q == 0));
	assign rd_addr = {cur_r[RW-1:0], cur_c[CW-1:0]};

	// store: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (in_valid && in_ready && mode == MODE_LOAD &&
			{1'b0, pixel_row} < eff_h && {1'b0, pixel_col} < eff_w) begin
			mem[{pixel_row[RW-1:0], pixel_col[CW-1:0]}] <= pixel_value;
		end
		rd_data_q <= mem[rd_addr];
	end

	// middle pair of the sorted values, count 2..8
	assign mid_hi  = cnt_q[3:1];
	assign mid_lo  = cnt_q[3:1] - 3'd1;
	assign mid_sum = {1'b0, vals_q[mid_lo]} + {1'b0, vals_q[mid_hi]};

	assign div_req.start    = (state_q == S_NEXT_BOX) && (cnt_q >= 7'd2);
	assign div_req.dividend = sum_q;
	assign div_req.divisor  = cnt_q;

	dhfm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign res_load     = (state_q == S_OUT) && (!out_valid_q || out_ready);
	assign in_ready     = (state_q == S_IDLE);
	assign out_valid    = out_valid_q;
	assign result_row   = res_row_q;
	assign result_col   = res_col_q;
	assign filled_value = res_value_q;
	assign fill_status  = res_status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= res_load || (out_valid_q && !out_ready);
			if (res_load) begin
				res_row_q    <= row_q;
				res_col_q    <= col_q;
				res_value_q  <= value_q;
				res_status_q <= status_q;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && mode == MODE_QUERY) begin
						row_q <= pixel_row;
						col_q <= pixel_col;
						dr_q  <= '0;
						dc_q  <= '0;
						value_q <= '0;
						if ({1'b0, pixel_row} < eff_h && {1'b0, pixel_col} < eff_w) begin
							state_q <= S_CENTER_RD;
						end else begin
							status_q <= ST_OUTSIDE;
							state_q  <= S_OUT;
						end
					end
				end
				S_CENTER_RD: state_q <= S_CENTER;
				S_CENTER: begin
					if (rd_data_q != 8'd0) begin
						value_q  <= rd_data_q;
						status_q <= ST_KEPT;
						state_q  <= S_OUT;
					end else begin
						rad_q  <= 4'd1;
						dr_q   <= -SW'(1);
						dc_q   <= -SW'(1);
						cnt_q  <= '0;
						sum_q  <= '0;
						pend_q <= 1'b0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					// pend_q marks the read issued last cycle as a valid pixel
					if (pend_q && rd_data_q != 8'd0) begin
						if (rad_q == 4'd1) vals_q[cnt_q[2:0]] <= rd_data_q;
						cnt_q <= cnt_q + 7'd1;
						sum_q <= sum_q + 15'(rd_data_q);
					end
					pend_q <= cur_in;
					if (dr_q == $signed({7'd0, rad_q}) + SW'(1)) begin
						if (rad_q == 4'd1 && (cnt_q + 7'(pend_q && rd_data_q != 0)) >= 7'd2) begin
							si_q <= 3'd1;
							sj_q <= 3'd1;
							state_q <= S_SORT;
						end else begin
							state_q <= S_NEXT_BOX;
						end
					end else if (dc_q == $signed({7'd0, rad_q})) begin
						dc_q <= -$signed({7'd0, rad_q});
						dr_q <= dr_q + SW'(1);
					end else begin
						dc_q <= dc_q + SW'(1);
					end
				end
				S_SORT: begin
					// one compare-and-swap per cycle, insertion order
					if (si_q >= cnt_q[2:0] && cnt_q != 7'd8) begin
						state_q <= S_MID;
					end else if (sj_q != 3'd0 && vals_q[sj_q - 3'd1] > vals_q[sj_q]) begin
						vals_q[sj_q]        <= vals_q[sj_q - 3'd1];
						vals_q[sj_q - 3'd1] <= vals_q[sj_q];
						sj_q <= sj_q - 3'd1;
					end else if (si_q == 3'd7) begin
						state_q <= S_MID;
					end else begin
						si_q <= si_q + 3'd1;
						sj_q <= si_q + 3'd1;
					end
				end
				S_MID: begin
					if (cnt_q[0]) value_q <= vals_q[mid_hi];
					else value_q <= mid_sum[8:1];
					status_q <= ST_MEDIAN;
					state_q  <= S_OUT;
				end
				S_NEXT_BOX: begin
					if (cnt_q >= 7'd2) begin
						state_q <= S_DIV_WAIT;
					end else if (rad_q == 4'(MAX_RAD)) begin
						status_q <= ST_UNFILLED;
						value_q  <= '0;
						state_q  <= S_OUT;
					end else begin
						rad_q  <= rad_q + 4'd1;
						dr_q   <= -$signed({7'd0, rad_q + 4'd1});
						dc_q   <= -$signed({7'd0, rad_q + 4'd1});
						cnt_q  <= '0;
						sum_q  <= '0;
						pend_q <= 1'b0;
						state_q <= S_SCAN;
					end
				end
				S_DIV_WAIT: begin
					if (div_rsp.done) begin
						value_q  <= div_rsp.quotient;
						status_q <= ST_MEAN;
						state_q  <= S_OUT;
					end
				end
				// hold the finished word until the output register is free
				S_OUT: if (res_load) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== tb/disparity_hole_fill_median_top_test.sv =====
// Testbench for disparity_hole_fill_median_top: loads frames, queries filled pixels and
// checks every result word against an in-bench predictor of the hole filling.
// Depends on dhfm_pkg and the RTL of the block.
module disparity_hole_fill_median_top_test
	import dhfm_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int COLS = 256;
	localparam int ROWS = 256;
	localparam int BOX = 9;
	localparam longint CYCLE_LIMIT = 64'd3_000_000;

	typedef struct {
		logic [7:0] row;
		logic [7:0] col;
		logic [7:0] value;
		fill_status_t status;
	} fill_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [0:0] cfg_index = REG_FRAME_WIDTH;
	logic [8:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic mode = MODE_LOAD;
	logic [7:0] pixel_row = '0;
	logic [7:0] pixel_col = '0;
	logic [7:0] pixel_value = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [7:0] result_row;
	logic [7:0] result_col;
	logic [7:0] filled_value;
	logic [2:0] fill_status;

	// predictor state: its own copy of the store and frame size
	logic [7:0] disp_map [COLS*ROWS];
	logic [8:0] width_reg = 9'd256;
	logic [8:0] height_reg = 9'd256;

	fill_word_t fill_queue[$];
	int n_errors = 0;
	longint cycles = 0;
	bit stall_free = 1'b0; // stretches with no idling on either side

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	disparity_hole_fill_median_top i_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready), .mode(mode),
		.pixel_row(pixel_row), .pixel_col(pixel_col), .pixel_value(pixel_value),
		.out_valid(out_valid), .out_ready(out_ready), .result_row(result_row),
		.result_col(result_col), .filled_value(filled_value), .fill_status(fill_status)
	);

	function automatic int eff_w();
		return (width_reg > COLS) ? COLS : int'(width_reg);
	endfunction

	function automatic int eff_h();
		return (height_reg > ROWS) ? ROWS : int'(height_reg);
	endfunction

	// nonzero in-frame pixels of a window, center excluded
	function automatic int gather_window(input int row, input int col, input int rad,
			output int sum, ref logic [7:0] vals[8]);
		int n;
		sum = 0;
		n = 0;
		for (int r = row - rad; r <= row + rad; r++)
			for (int c = col - rad; c <= col + rad; c++) begin
				if (r == row && c == col) continue;
				if (r < 0 || c < 0 || r >= eff_h() || c >= eff_w()) continue;
				if (disp_map[r*COLS+c] == 0) continue;
				if (n < 8) vals[n] = disp_map[r*COLS+c];
				sum += disp_map[r*COLS+c];
				n++;
			end
		return n;
	endfunction

	function automatic fill_word_t predict_fill(input int row, input int col);
		fill_word_t w;
		logic [7:0] vals[8];
		logic [7:0] t;
		int n, sum;
		w.row = 8'(row);
		w.col = 8'(col);
		w.value = '0;
		if (row >= eff_h() || col >= eff_w()) begin
			w.status = ST_OUTSIDE;
		end else if (disp_map[row*COLS+col] != 0) begin
			w.value = disp_map[row*COLS+col];
			w.status = ST_KEPT;
		end else begin
			w.status = ST_UNFILLED;
			n = gather_window(row, col, 1, sum, vals);
			if (n >= 2) begin
				for (int i = 1; i < n; i++)
					for (int j = i; j > 0 && vals[j-1] > vals[j]; j--) begin
						t = vals[j];
						vals[j] = vals[j-1];
						vals[j-1] = t;
					end
				if (n % 2 == 0) w.value = 8'((int'(vals[n/2-1]) + vals[n/2]) / 2);
				else w.value = vals[n/2];
				w.status = ST_MEDIAN;
			end else begin
				for (int b = 5; b <= BOX; b += 2) begin
					n = gather_window(row, col, b / 2, sum, vals);
					if (n >= 2) begin
						w.value = 8'(sum / n);
						w.status = ST_MEAN;
						break;
					end
				end
			end
		end
		return w;
	endfunction

	// result side: random stall per word, compare on accept
	initial begin
		fill_word_t exp_w;
		int stall;
		forever begin
			@(negedge clk);
			out_ready <= 1'b0;
			stall = stall_free ? 0 : $urandom_range(0, 15);
			repeat (stall) @(negedge clk);
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			if (fill_queue.size() == 0) begin
				$error("result word with nothing expected: row %0d col %0d", result_row,
					result_col);
				n_errors++;
			end else begin
				exp_w = fill_queue.pop_front();
				if (result_row !== exp_w.row) begin
					$error("result_row exp %0d got %0d", exp_w.row, result_row);
					n_errors++;
				end
				if (result_col !== exp_w.col) begin
					$error("result_col exp %0d got %0d", exp_w.col, result_col);
					n_errors++;
				end
				if (filled_value !== exp_w.value) begin
					$error("filled_value exp %0d got %0d", exp_w.value, filled_value);
					n_errors++;
				end
				if (fill_status !== exp_w.status) begin
					$error("fill_status exp %0d got %0d", exp_w.status, fill_status);
					n_errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// one input word; model is updated at the accept edge; valid drops only
	// before an idle gap or when the sender drains
	task automatic send_word(input logic m, input int row, input int col, input int val);
		int gap;
		gap = stall_free ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		pixel_row <= 8'(row);
		pixel_col <= 8'(col);
		pixel_value <= 8'(val);
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (m == MODE_QUERY) fill_queue = {fill_queue, predict_fill(row, col)};
		else if (row < eff_h() && col < eff_w()) disp_map[row*COLS+col] = 8'(val);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (fill_queue.size() != 0) @(negedge clk);
		repeat (250) @(negedge clk);
	endtask

	task automatic write_reg(input logic [0:0] idx, input int val);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= 9'(val);
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_FRAME_WIDTH) width_reg = 9'(val);
		else height_reg = 9'(val);
	endtask

	// holes are likely so wider windows and unfilled cases show up
	function automatic int rand_disp();
		case ($urandom_range(0, 3))
			0, 1: return 0;
			2: return $urandom_range(1, 255);
			default: return $urandom_range(0, 1) ? 255 : 1;
		endcase
	endfunction

	task automatic load_frame(input int w, input int h, input int density);
		for (int r = 0; r < h; r++)
			for (int c = 0; c < w; c++)
				send_word(MODE_LOAD, r, c, ($urandom_range(0, 99) < density) ?
					$urandom_range(1, 255) : 0);
	endtask

	// extremes of fields, every status, out-of-frame load and query
	task automatic test_directed();
		write_reg(REG_FRAME_WIDTH, 5);
		write_reg(REG_FRAME_HEIGHT, 4);
		for (int r = 0; r < 4; r++)
			for (int c = 0; c < 5; c++) send_word(MODE_LOAD, r, c, 0);
		send_word(MODE_QUERY, 0, 0, 8'hFF);    // unfilled
		send_word(MODE_LOAD, 3, 4, 255);
		send_word(MODE_LOAD, 0, 4, 1);
		send_word(MODE_QUERY, 0, 0, 0);       // wide mean
		send_word(MODE_LOAD, 0, 1, 200);
		send_word(MODE_LOAD, 1, 1, 100);
		send_word(MODE_LOAD, 1, 0, 51);
		send_word(MODE_QUERY, 0, 0, 0);       // median of odd count
		send_word(MODE_LOAD, 255, 255, 255);  // load outside, ignored
		send_word(MODE_QUERY, 255, 255, 0);   // query outside
		send_word(MODE_QUERY, 0, 4, 0);       // kept
		send_word(MODE_QUERY, 3, 4, 0);       // kept max
		send_word(MODE_QUERY, 2, 4, 0);
		send_word(MODE_QUERY, 1, 2, 0);       // median of even count
		write_reg(REG_FRAME_WIDTH, 0);        // zero size
		send_word(MODE_QUERY, 0, 0, 0);
		write_reg(REG_FRAME_WIDTH, 511);      // oversized clamps to 256
		write_reg(REG_FRAME_HEIGHT, 1);
		send_word(MODE_LOAD, 0, 255, 7);
		send_word(MODE_QUERY, 0, 255, 0);
		send_word(MODE_QUERY, 1, 0, 0);
	endtask

	// small frames, loaded fully, then random queries; pixels outside stay unread
	task automatic test_random_frames();
		int w, h, nq;
		for (int f = 0; f < 26; f++) begin
			stall_free = (f % 5 == 4);
			w = (f % 6 == 0) ? 1 : $urandom_range(1, 9);
			h = (f % 7 == 0) ? 1 : $urandom_range(1, 9);
			write_reg(REG_FRAME_WIDTH, w);
			write_reg(REG_FRAME_HEIGHT, h);
			load_frame(w, h, $urandom_range(3, 70));
			nq = 18;
			for (int q = 0; q < nq; q++) begin
				if ($urandom_range(0, 9) == 0)
					send_word(MODE_LOAD, $urandom_range(0, 255), $urandom_range(0, 255),
						rand_disp());
				else if ($urandom_range(0, 9) == 0)
					send_word(MODE_QUERY, $urandom_range(0, 255), $urandom_range(0, 255),
						$urandom_range(0, 255));
				else
					send_word(MODE_QUERY, $urandom_range(0, h - 1), $urandom_range(0, w - 1),
						$urandom_range(0, 255));
			end
		end
		stall_free = 1'b0;
	endtask

	// a 6x6 block at the top of the range of a full-size frame; only written pixels are read
	task automatic test_wide_strip();
		write_reg(REG_FRAME_WIDTH, 256);
		write_reg(REG_FRAME_HEIGHT, 256);
		for (int r = 250; r < 256; r++)
			for (int c = 250; c < 256; c++) send_word(MODE_LOAD, r, c, rand_disp());
		// queries stay at least 4 pixels inside the written block or on its far edge
		for (int q = 0; q < 12; q++)
			send_word(MODE_QUERY, $urandom_range(254, 255), $urandom_range(254, 255), 0);
		send_word(MODE_QUERY, 255, 255, 0);
	endtask

	initial begin
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_random_frames();
		test_wide_strip();
		wait_drained();
		if (n_errors == 0) $display("DONE: 0 errors");
		else $display("DONE: errors detected");
		$finish;
	end
endmodule
